@@ src/lrb_pkg.sv @@
// Package: types, codes and constants of the link reconnect backoff supervisor.
`timescale 1ns / 1ps
`default_nettype none

package lrb_pkg;

	localparam int unsigned TW = 20;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [TW-1:0] TIMER_MAX = '1;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_MIN     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_MAX     = 2'd2;

	// Register reset values
	localparam logic [TW-1:0] RST_CONNECT_TIMEOUT = 20'd10000;
	localparam logic [TW-1:0] RST_BACKOFF_MIN     = 20'd1000;
	localparam logic [TW-1:0] RST_BACKOFF_MAX     = 20'd30000;

	// Mode codes as reported on the result word
	localparam logic [1:0] CODE_IDLE         = 2'd0;
	localparam logic [1:0] CODE_CONNECTING   = 2'd1;
	localparam logic [1:0] CODE_CONNECTED    = 2'd2;
	localparam logic [1:0] CODE_DISCONNECTED = 2'd3;

	// Input word kinds
	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_START = 1'b1;

	typedef enum logic [3:0] {
		MODE_IDLE         = 4'b0001,
		MODE_CONNECTING   = 4'b0010,
		MODE_CONNECTED    = 4'b0100,
		MODE_DISCONNECTED = 4'b1000
	} mode_t;

	typedef struct packed {
		logic [TW-1:0] connect_timeout;
		logic [TW-1:0] backoff_min;
		logic [TW-1:0] backoff_max;
	} lrb_cfg_t;

	typedef struct packed {
		mode_t         mode;
		logic [TW-1:0] attempt_timer;
		logic [TW-1:0] wait_timer;
		logic [TW-1:0] backoff_delay;
	} lrb_state_t;

	typedef struct packed {
		logic [1:0]    link_mode_out;
		logic          begin_attempt;
		logic          abort_attempt;
		logic          is_up;
		logic [TW-1:0] retry_delay;
	} lrb_result_t;

	function automatic logic [1:0] mode_code(input mode_t m);
		logic [1:0] c;
		unique case (m)
			MODE_IDLE:         c = CODE_IDLE;
			MODE_CONNECTING:   c = CODE_CONNECTING;
			MODE_CONNECTED:    c = CODE_CONNECTED;
			MODE_DISCONNECTED: c = CODE_DISCONNECTED;
			default:           c = CODE_IDLE;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

@@ src/lrb_if.sv @@
// Interfaces: sample channel (tick/start words) and report channel (result words).
`timescale 1ns / 1ps
`default_nettype none

interface lrb_sample_if;
	logic valid;
	logic ready;
	logic kind;
	logic link_up;

	modport source (output valid, output kind, output link_up, input ready);
	modport sink   (input valid, input kind, input link_up, output ready);
endinterface

interface lrb_report_if;
	logic        valid;
	logic        ready;
	logic [1:0]  link_mode_out;
	logic        begin_attempt;
	logic        abort_attempt;
	logic        is_up;
	logic [19:0] retry_delay;

	modport source (output valid, output link_mode_out, output begin_attempt,
		output abort_attempt, output is_up, output retry_delay, input ready);
	modport sink   (input valid, input link_mode_out, input begin_attempt,
		input abort_attempt, input is_up, input retry_delay, output ready);
endinterface

`default_nettype wire

@@ src/lrb_cfg.sv @@
// Configuration register file: timeout and backoff limits.
`timescale 1ns / 1ps
`default_nettype none

module lrb_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [lrb_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [lrb_pkg::TW-1:0]        cfg_data,
	output lrb_pkg::lrb_cfg_t                  cfg
);
	import lrb_pkg::*;

	lrb_cfg_t cfg_q;

	// Indexes past the last register are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.connect_timeout <= RST_CONNECT_TIMEOUT;
			cfg_q.backoff_min     <= RST_BACKOFF_MIN;
			cfg_q.backoff_max     <= RST_BACKOFF_MAX;
		end else if (cfg_we) begin
			if (cfg_idx == CFG_CONNECT_TIMEOUT) begin
				cfg_q.connect_timeout <= cfg_data;
			end
			if (cfg_idx == CFG_BACKOFF_MIN) begin
				cfg_q.backoff_min <= cfg_data;
			end
			if (cfg_idx == CFG_BACKOFF_MAX) begin
				cfg_q.backoff_max <= cfg_data;
			end
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ src/lrb_step.sv @@
// Next-state and result logic for one tick or start word.
`timescale 1ns / 1ps
`default_nettype none

module lrb_step (
	input  wire lrb_pkg::lrb_state_t st,
	input  wire lrb_pkg::lrb_cfg_t   cfg,
	input  wire logic                kind,
	input  wire logic                link_up,
	output lrb_pkg::lrb_state_t      nxt,
	output lrb_pkg::lrb_result_t     rsp
);
	import lrb_pkg::*;

	logic [TW-1:0] att_inc;
	logic [TW-1:0] wait_inc;
	logic [TW:0]   dbl;
	logic [TW-1:0] dbl_capped;
	logic          begin_req;
	logic          abort_req;

	// Saturating timer increments
	assign att_inc  = (st.attempt_timer == TIMER_MAX) ? TIMER_MAX : st.attempt_timer + 1'b1;
	assign wait_inc = (st.wait_timer == TIMER_MAX) ? TIMER_MAX : st.wait_timer + 1'b1;

	// Doubled delay, capped at backoff_max
	assign dbl        = {st.backoff_delay, 1'b0};
	assign dbl_capped = (dbl > {1'b0, cfg.backoff_max}) ? cfg.backoff_max : dbl[TW-1:0];

	always_comb begin
		nxt       = st;
		begin_req = 1'b0;
		abort_req = 1'b0;
		priority if (kind == KIND_START) begin
			// restart from any mode
			nxt.mode          = MODE_CONNECTING;
			nxt.attempt_timer = '0;
			nxt.wait_timer    = '0;
			nxt.backoff_delay = cfg.backoff_min;
			begin_req         = 1'b1;
		end else begin
			unique case (st.mode)
				MODE_CONNECTING: begin
					if (link_up) begin
						nxt.mode          = MODE_CONNECTED;
						nxt.backoff_delay = cfg.backoff_min;
					end else begin
						nxt.attempt_timer = att_inc;
						if (att_inc > cfg.connect_timeout) begin
							abort_req      = 1'b1;
							nxt.mode       = MODE_DISCONNECTED;
							nxt.wait_timer = '0;
						end
					end
				end
				MODE_CONNECTED: begin
					if (!link_up) begin
						nxt.mode          = MODE_DISCONNECTED;
						nxt.wait_timer    = '0;
						nxt.backoff_delay = cfg.backoff_min;
					end
				end
				MODE_DISCONNECTED: begin
					nxt.wait_timer = wait_inc;
					if (wait_inc >= st.backoff_delay) begin
						begin_req         = 1'b1;
						nxt.mode          = MODE_CONNECTING;
						nxt.attempt_timer = '0;
						nxt.backoff_delay = dbl_capped;
					end
				end
				default: begin
					// idle: nothing changes
				end
			endcase
		end
	end

	// Result word
	always_comb begin
		rsp.link_mode_out = mode_code(nxt.mode);
		rsp.begin_attempt = begin_req;
		rsp.abort_attempt = abort_req;
		rsp.is_up         = (nxt.mode == MODE_CONNECTED) && link_up;
		rsp.retry_delay   = nxt.backoff_delay;
	end

endmodule

`default_nettype wire

@@ src/link_reconnect_backoff_fsm.sv @@
// Top level: link reconnect supervisor with exponential backoff.
//
//  channel  | dir | handshake    | word
//  ---------+-----+--------------+-----------------------------------------------
//  sample   | in  | valid/ready  | kind, link_up
//  report   | out | valid/ready  | link_mode_out, begin_attempt, abort_attempt,
//           |     |              | is_up, retry_delay
//  cfg      | in  | cfg_we       | cfg_idx, cfg_data (write only)
//
// One word per cycle sustained while the report side keeps ready; a word passes the input
// register, then the next-state logic into the result register, before report valid rises.
// The supervisor state updates as a word moves from the input register to the result
// register, so consecutive words see each other's effects with no bubble.
// A stalled report holds the result register; the input register still takes a word
// while the result register waits, and sample.ready drops only when both are full.
// Reset (arst_n, async low) clears the state to idle and the registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module link_reconnect_backoff_fsm (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	lrb_sample_if.sink                         sample,
	lrb_report_if.source                       report,
	input  wire logic                          cfg_we,
	input  wire logic [lrb_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [lrb_pkg::TW-1:0]        cfg_data
);
	import lrb_pkg::*;

	lrb_cfg_t    cfg;
	lrb_state_t  state_q;
	lrb_state_t  state_nxt;
	lrb_result_t rsp;
	lrb_result_t rsp_q;

	logic valid_s1;
	logic kind_s1;
	logic link_up_s1;
	logic out_valid_q;
	logic out_free;
	logic advance;

	lrb_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	lrb_step u_step (
		.st      (state_q),
		.cfg     (cfg),
		.kind    (kind_s1),
		.link_up (link_up_s1),
		.nxt     (state_nxt),
		.rsp     (rsp)
	);

	// Flow control
	assign out_free     = !out_valid_q || report.ready;
	assign advance      = valid_s1 && out_free;
	assign sample.ready = !valid_s1 || out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			kind_s1    <= sample.kind;
			link_up_s1 <= sample.link_up;
		end
	end

	// Supervisor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode          <= MODE_IDLE;
			state_q.attempt_timer <= '0;
			state_q.wait_timer    <= '0;
			state_q.backoff_delay <= RST_BACKOFF_MIN;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp;
		end
	end

	assign report.valid         = out_valid_q;
	assign report.link_mode_out = rsp_q.link_mode_out;
	assign report.begin_attempt = rsp_q.begin_attempt;
	assign report.abort_attempt = rsp_q.abort_attempt;
	assign report.is_up         = rsp_q.is_up;
	assign report.retry_delay   = rsp_q.retry_delay;

	// A word held in the input register waits until the result register frees up
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1)
		else $error("input word dropped while result register was full");

	// Begin and abort are never raised together
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(rsp_q.begin_attempt && rsp_q.abort_attempt))
		else $error("begin and abort raised in one word");

	// An abort always lands in disconnected mode
	a_abort_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && rsp_q.abort_attempt |-> rsp_q.link_mode_out == CODE_DISCONNECTED)
		else $error("abort without disconnected mode");

	// A begin always lands in connecting mode, and is_up only when connected
	a_begin_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!rsp_q.begin_attempt || rsp_q.link_mode_out == CODE_CONNECTING)
			&& (!rsp_q.is_up || rsp_q.link_mode_out == CODE_CONNECTED))
		else $error("mode does not match begin or is_up flag");

endmodule

`default_nettype wire

@@ tb/link_reconnect_backoff_fsm_tb.sv @@
// Testbench: link reconnect supervisor, mode predictor, word scoreboard, directed and random tests.
`timescale 1ns / 1ps

module link_reconnect_backoff_fsm_tb;
	import lrb_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [TW-1:0]        cfg_data;

	lrb_sample_if sample_ch ();
	lrb_report_if report_ch ();

	link_reconnect_backoff_fsm u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample_ch),
		.report   (report_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// Register copies as last written
	logic [TW-1:0] timeout_reg;
	logic [TW-1:0] min_reg;
	logic [TW-1:0] max_reg;

	// Supervisor state as predicted
	logic [1:0]    mode_now;
	logic [TW-1:0] attempt_ticks;
	logic [TW-1:0] wait_ticks;
	logic [TW-1:0] delay_now;

	lrb_result_t pending_reports[$];
	int          mismatch_count = 0;
	bit          gaps_on;
	bit          stalls_on;
	int          hold_cycles = 0;

	always #5 clk = ~clk;

	function automatic logic [TW-1:0] sat_incr(input logic [TW-1:0] v);
		return (v == TIMER_MAX) ? v : v + 1'b1;
	endfunction

	// Advance the predicted supervisor by one word and return the report it yields
	function automatic lrb_result_t step_supervisor(input logic kind, input logic up);
		lrb_result_t r;
		logic [TW:0] doubled;
		r.begin_attempt = 1'b0;
		r.abort_attempt = 1'b0;
		if (kind == KIND_START) begin
			mode_now = CODE_CONNECTING;
			attempt_ticks = '0;
			wait_ticks = '0;
			delay_now = min_reg;
			r.begin_attempt = 1'b1;
		end else begin
			case (mode_now)
				CODE_CONNECTING: begin
					if (up) begin
						mode_now = CODE_CONNECTED;
						delay_now = min_reg;
					end else begin
						attempt_ticks = sat_incr(attempt_ticks);
						if (attempt_ticks > timeout_reg) begin
							r.abort_attempt = 1'b1;
							mode_now = CODE_DISCONNECTED;
							wait_ticks = '0;
						end
					end
				end
				CODE_CONNECTED: begin
					if (!up) begin
						mode_now = CODE_DISCONNECTED;
						wait_ticks = '0;
						delay_now = min_reg;
					end
				end
				CODE_DISCONNECTED: begin
					wait_ticks = sat_incr(wait_ticks);
					if (wait_ticks >= delay_now) begin
						r.begin_attempt = 1'b1;
						mode_now = CODE_CONNECTING;
						attempt_ticks = '0;
						doubled = {1'b0, delay_now} << 1;
						// doubled delay capped, even when the cap is below the minimum
						if (doubled > {1'b0, max_reg})
							delay_now = max_reg;
						else
							delay_now = doubled[TW-1:0];
					end
				end
				default: ;
			endcase
		end
		r.link_mode_out = mode_now;
		r.is_up = (mode_now == CODE_CONNECTED) && up;
		r.retry_delay = delay_now;
		return r;
	endfunction

	// Offer one word, wait for it to be taken, then predict its report
	task automatic send_sample(input logic kind, input logic up);
		int gap;
		gap = 0;
		if (gaps_on)
			while ($urandom_range(0, 99) < 37)
				gap++;
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.kind <= kind;
		sample_ch.link_up <= up;
		do @(posedge clk); while (!sample_ch.ready);
		pending_reports.push_back(step_supervisor(kind, up));
	endtask

	// Stop offering and let every outstanding report come back
	task automatic drain_reports();
		sample_ch.valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all three registers on consecutive cycles; only called with the block idle
	task automatic write_regs(input logic [TW-1:0] cto, input logic [TW-1:0] mn,
		input logic [TW-1:0] mx);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_CONNECT_TIMEOUT;
		cfg_data <= cto;
		@(posedge clk);
		cfg_idx <= CFG_BACKOFF_MIN;
		cfg_data <= mn;
		@(posedge clk);
		cfg_idx <= CFG_BACKOFF_MAX;
		cfg_data <= mx;
		@(posedge clk);
		cfg_we <= 1'b0;
		timeout_reg = cto;
		min_reg = mn;
		max_reg = mx;
	endtask

	// Mostly plausible link behavior per mode, with some pure noise and rare restarts
	task automatic random_samples(input int count);
		logic kind;
		logic up;
		int   roll;
		repeat (count) begin
			roll = $urandom_range(0, 99);
			kind = (roll < 3) ? KIND_START : KIND_TICK;
			if (roll >= 90)
				up = 1'($urandom_range(0, 1));
			else if (mode_now == CODE_CONNECTING)
				up = ($urandom_range(0, 99) < 20);
			else if (mode_now == CODE_CONNECTED)
				up = ($urandom_range(0, 99) < 88);
			else
				up = 1'($urandom_range(0, 1));
			if (roll >= 97)
				kind = 1'($urandom_range(0, 1));
			send_sample(kind, up);
		end
	endtask

	// Mode changes by start, link up and link loss at reset register values
	task automatic test_directed_defaults();
		send_sample(KIND_TICK, 1'b0);
		send_sample(KIND_TICK, 1'b1);
		send_sample(KIND_START, 1'b0);
		send_sample(KIND_TICK, 1'b0);
		send_sample(KIND_TICK, 1'b1);
		send_sample(KIND_TICK, 1'b1);
		send_sample(KIND_START, 1'b1);
		send_sample(KIND_TICK, 1'b1);
		send_sample(KIND_TICK, 1'b0);
		send_sample(KIND_START, 1'b0);
	endtask

	// Attempt timeout, retry, doubling up to the cap, and a lost link resetting the delay
	task automatic test_timeout_backoff();
		drain_reports();
		write_regs(20'd1, 20'd1, 20'd3);
		send_sample(KIND_START, 1'b0);
		repeat (3) send_sample(KIND_TICK, 1'b0);
		repeat (3) send_sample(KIND_TICK, 1'b0);
		repeat (2) send_sample(KIND_TICK, 1'b0);
		send_sample(KIND_TICK, 1'b1);
		send_sample(KIND_TICK, 1'b0);
		send_sample(KIND_TICK, 1'b0);
	endtask

	// Zero timeout and zero delays; run without any idling on either side
	task automatic test_low_extremes();
		drain_reports();
		write_regs('0, '0, '0);
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		send_sample(KIND_START, 1'b0);
		random_samples(150);
		gaps_on = 1'b1;
		stalls_on = 1'b1;
	endtask

	// All registers at their top value: an attempt never times out
	task automatic test_high_extremes();
		drain_reports();
		write_regs(TIMER_MAX, TIMER_MAX, TIMER_MAX);
		random_samples(140);
	endtask

	// Cap below the minimum still limits the doubled delay
	task automatic test_max_below_min();
		drain_reports();
		write_regs(20'd3, 20'd6, 20'd2);
		send_sample(KIND_START, 1'b0);
		random_samples(150);
	endtask

	// Several random small settings; state carries over each register change
	task automatic test_random_settings();
		repeat (4) begin
			drain_reports();
			write_regs(TW'($urandom_range(0, 12)), TW'($urandom_range(0, 6)),
				TW'($urandom_range(1, 40)));
			random_samples(150);
		end
	endtask

	// Report side held off long enough for the block to fill and stall its input
	task automatic test_backpressure();
		drain_reports();
		gaps_on = 1'b0;
		hold_cycles = 200;
		random_samples(40);
		gaps_on = 1'b1;
	endtask

	// Report side readiness: long hold when asked, else random stalls
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			report_ch.ready <= 1'b0;
			hold_cycles--;
		end else if (stalls_on) begin
			report_ch.ready <= ($urandom_range(0, 99) >= 37);
		end else begin
			report_ch.ready <= 1'b1;
		end
	end

	// Compare each taken report word with the oldest prediction
	always @(posedge clk) begin : check_report
		lrb_result_t want;
		if (arst_n && report_ch.valid && report_ch.ready) begin
			if (pending_reports.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: report word with none expected: mode=%0d delay=%0d",
						$realtime, report_ch.link_mode_out, report_ch.retry_delay);
			end else begin
				want = pending_reports.pop_front();
				if (report_ch.link_mode_out !== want.link_mode_out ||
					report_ch.begin_attempt !== want.begin_attempt ||
					report_ch.abort_attempt !== want.abort_attempt ||
					report_ch.is_up !== want.is_up ||
					report_ch.retry_delay !== want.retry_delay) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"%0t: mismatch: expected mode=%0d begin=%0b abort=%0b up=%0b ",
							"delay=%0d, got mode=%0d begin=%0b abort=%0b up=%0b delay=%0d"},
							$realtime, want.link_mode_out, want.begin_attempt,
							want.abort_attempt, want.is_up, want.retry_delay,
							report_ch.link_mode_out, report_ch.begin_attempt,
							report_ch.abort_attempt, report_ch.is_up, report_ch.retry_delay);
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= CFG_CONNECT_TIMEOUT;
		cfg_data <= '0;
		sample_ch.valid <= 1'b0;
		sample_ch.kind <= KIND_TICK;
		sample_ch.link_up <= 1'b0;
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		timeout_reg = RST_CONNECT_TIMEOUT;
		min_reg = RST_BACKOFF_MIN;
		max_reg = RST_BACKOFF_MAX;
		mode_now = CODE_IDLE;
		attempt_ticks = '0;
		wait_ticks = '0;
		delay_now = RST_BACKOFF_MIN;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_defaults();
		test_timeout_backoff();
		test_low_extremes();
		test_high_extremes();
		test_max_below_min();
		test_random_settings();
		test_backpressure();
		drain_reports();

		if (mismatch_count == 0 && pending_reports.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Run limit, far above the slowest legal run
	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

@@ sim.f @@
src/lrb_pkg.sv
src/lrb_if.sv
src/lrb_cfg.sv
src/lrb_step.sv
src/link_reconnect_backoff_fsm.sv
tb/link_reconnect_backoff_fsm_tb.sv
